>>> hw/rtl/bce_pkg.sv
`default_nettype none

package bce_pkg;

    localparam int BUTTONS   = 87;
    localparam int ENCODERS  = 7;
    localparam int LANES     = 8;
    localparam int ENC_LANES = 4;
    localparam int ROWS      = 11;
    localparam int LANE_W    = $clog2(LANES);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int ID_W      = 7;

    localparam logic [7:0] DEAD_RESET = 8'd20;

    // frame positions
    localparam logic [3:0] REG_BTN_LAST = 4'd8;
    localparam logic [3:0] REG_ENC_LO   = 4'd9;
    localparam logic [3:0] REG_ENC_HI   = 4'd10;
    localparam logic [3:0] REG_BTN_TOP  = 4'd11;
    localparam logic [3:0] REG_BTN_HI   = 4'd12;

    // storage rows for the two bytes that sit after the encoder bytes
    localparam logic [ROW_W-1:0] ROW_HI  = ROW_W'(9);
    localparam logic [ROW_W-1:0] ROW_TOP = ROW_W'(10);

    localparam logic [ID_W-1:0] ID_HI  = ID_W'(72);
    localparam logic [ID_W-1:0] ID_TOP = ID_W'(80);

    localparam int ENC_HI_BASE = 4;

    localparam logic CFG_DEAD_SCANS = 1'b0;

    typedef enum logic [1:0] {
        PH_WAIT_PRESS = 2'd0,
        PH_PRESS_DEAD = 2'd1,
        PH_WAIT_REL   = 2'd2,
        PH_REL_DEAD   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_DETENT  = 2'd2
    } t_kind;

    localparam logic signed [1:0] STEP_NONE = 2'sd0;
    localparam logic signed [1:0] STEP_UP   = 2'sd1;
    localparam logic signed [1:0] STEP_DOWN = -2'sd1;

    typedef struct packed {
        t_kind                  kind;
        logic [ID_W-1:0]        id;
        logic signed [1:0]      step;
    } t_event;

endpackage

`default_nettype wire

>>> hw/rtl/bce_btn_lane.sv
`default_nettype none

module bce_btn_lane (
    input  bce_pkg::t_phase             i_phase,
    input  logic [7:0]                  i_count,
    input  logic                        i_raw,
    input  logic                        i_en,
    input  logic [7:0]                  i_dead,
    input  logic [bce_pkg::ID_W-1:0]    i_id,
    output bce_pkg::t_phase             o_phase,
    output logic [7:0]                  o_count,
    output logic                        o_fire,
    output bce_pkg::t_event             o_event
);
    import bce_pkg::*;

    logic [7:0] w_dec;

    assign w_dec = i_count - 8'd1;

    always_comb begin
        o_phase       = i_phase;
        o_count       = i_count;
        o_fire        = 1'b0;
        o_event.kind  = EV_PRESS;
        o_event.id    = i_id;
        o_event.step  = STEP_NONE;
        if (i_en) begin
            unique case (i_phase)
                PH_WAIT_PRESS: begin
                    if (!i_raw) begin
                        o_count = i_dead;
                        o_phase = PH_PRESS_DEAD;
                        o_fire  = 1'b1;
                    end
                end
                PH_PRESS_DEAD: begin
                    o_count = w_dec;
                    if (w_dec == 8'd0) o_phase = PH_WAIT_REL;
                end
                PH_WAIT_REL: begin
                    if (i_raw) begin
                        o_count      = i_dead;
                        o_phase      = PH_REL_DEAD;
                        o_fire       = 1'b1;
                        o_event.kind = EV_RELEASE;
                    end
                end
                PH_REL_DEAD: begin
                    o_count = w_dec;
                    if (w_dec == 8'd0) o_phase = PH_WAIT_PRESS;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bce_enc_lane.sv
`default_nettype none

module bce_enc_lane (
    input  logic [1:0]                  i_code,
    input  logic                        i_half,
    input  logic [1:0]                  i_pair,
    input  logic                        i_en,
    input  logic [bce_pkg::ID_W-1:0]    i_id,
    output logic [1:0]                  o_code,
    output logic                        o_half,
    output logic                        o_fire,
    output bce_pkg::t_event             o_event
);
    import bce_pkg::*;

    logic [1:0] w_code;
    logic [1:0] w_diff;

    // Gray pair to position code
    assign w_code = {i_pair[1], i_pair[1] ^ i_pair[0]};
    assign w_diff = i_code - w_code;

    always_comb begin
        o_code        = i_code;
        o_half        = i_half;
        o_fire        = 1'b0;
        o_event.kind  = EV_DETENT;
        o_event.id    = i_id;
        o_event.step  = STEP_UP;
        if (i_en && w_diff[0]) begin
            o_code = w_code;
            o_half = !i_half;
            if (w_diff == 2'd3) begin
                o_fire = i_half;
            end else begin
                o_fire       = !i_half;
                o_event.step = STEP_DOWN;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bce_merge.sv
`default_nettype none

module bce_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [bce_pkg::LANES-1:0] i_fire,
    input  bce_pkg::t_event     i_ev [bce_pkg::LANES],
    output logic                o_valid,
    input  logic                i_ready,
    output bce_pkg::t_event     o_ev,
    output logic                o_last
);
    import bce_pkg::*;

    logic [LANES-1:0]   r_pend;
    t_event             r_slot [LANES];
    logic               r_ovalid;
    t_event             r_oev;
    logic               r_olast;

    logic [LANES-1:0]   w_pick;
    logic [LANE_W-1:0]  w_idx;
    logic               w_olast;
    logic               w_load;
    logic               w_accept;

    assign w_pick  = r_pend & (~r_pend + LANES'(1));
    assign w_olast = (r_pend & ~w_pick) == '0;
    assign w_load  = (r_pend != '0) && (!r_ovalid || i_ready);
    assign o_ready = (r_pend == '0) || (w_load && w_olast);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        w_idx = '0;
        for (int i = 0; i < LANES; i++) begin
            if (w_pick[i]) w_idx = LANE_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            if (w_accept) r_pend <= i_fire;
            else if (w_load) r_pend <= r_pend & ~w_pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oev   <= r_slot[w_idx];
            r_olast <= w_olast;
        end
        if (w_accept) r_slot <= i_ev;
    end

    assign o_valid = r_ovalid;
    assign o_ev    = r_oev;
    assign o_last  = r_olast;

    a_accept_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_pend == '0 || $onehot(r_pend)))
        else $error("byte taken while events still queued");

    a_more_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_olast |-> r_pend != '0)
        else $error("non-final word with nothing behind it");

    a_final_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_olast && !w_accept |=> r_pend == '0)
        else $error("queue not empty after final word");

endmodule

`default_nettype wire

>>> hw/rtl/button_encoder_scan_decoder.sv
// Flow: the first event word of a byte moves from the slot registers to the output
// register when free; a new byte is taken as the last word loads. All lanes of a
// byte update in the accept cycle; the queue drains one word per cycle unless held.
// Reset: synchronous, active low; all debouncers, encoder states and the queue clear
// at once, dead time returns to 20 scans. No clearing pass.
`default_nettype none

module button_encoder_scan_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] reg_byte
    input  logic [3:0]  s_axis_tuser,   // [3:0] reg_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] source_id, [8:7] step, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bce_pkg::*;

    logic [7:0]     r_dead;
    t_phase         r_phase [ROWS][LANES];
    logic [7:0]     r_count [ROWS][LANES];
    logic [1:0]     r_code  [ENCODERS];
    logic           r_half  [ENCODERS];

    logic               w_accept;
    logic               w_btn_en;
    logic [ROW_W-1:0]   w_row;
    logic [ID_W-1:0]    w_base;
    logic               w_enc_lo;
    logic               w_enc_hi;

    t_phase             w_bph_n  [LANES];
    logic [7:0]         w_bcnt_n [LANES];
    logic [LANES-1:0]   w_bfire;
    t_event             w_bev    [LANES];

    logic [1:0]         w_ecode_n [ENC_LANES];
    logic               w_ehalf_n [ENC_LANES];
    logic [ENC_LANES-1:0] w_efire;
    t_event             w_eev     [ENC_LANES];

    logic [LANES-1:0]   w_fire;
    t_event             w_ev [LANES];
    t_event             w_out;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_DEAD_SCANS) ? {24'd0, r_dead} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead <= DEAD_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == CFG_DEAD_SCANS) begin
            r_dead <= pwdata[7:0];
        end
    end

    // row decode
    always_comb begin
        w_btn_en = 1'b1;
        w_row    = '0;
        w_base   = '0;
        if (s_axis_tuser <= REG_BTN_LAST) begin
            w_row  = ROW_W'(s_axis_tuser);
            w_base = {s_axis_tuser[3:0], 3'b000};
        end else if (s_axis_tuser == REG_BTN_HI) begin
            w_row  = ROW_HI;
            w_base = ID_HI;
        end else if (s_axis_tuser == REG_BTN_TOP) begin
            w_row  = ROW_TOP;
            w_base = ID_TOP;
        end else begin
            w_btn_en = 1'b0;
        end
    end

    assign w_enc_lo = s_axis_tuser == REG_ENC_LO;
    assign w_enc_hi = s_axis_tuser == REG_ENC_HI;

    for (genvar k = 0; k < LANES; k++) begin : g_btn
        logic w_en;
        // byte 11 has only seven buttons
        assign w_en = w_btn_en && !(k == LANES - 1 && s_axis_tuser == REG_BTN_TOP);

        bce_btn_lane u_lane (
            .i_phase (r_phase[w_row][k]),
            .i_count (r_count[w_row][k]),
            .i_raw   (s_axis_tdata[k]),
            .i_en    (w_en),
            .i_dead  (r_dead),
            .i_id    (w_base + ID_W'(k)),
            .o_phase (w_bph_n[k]),
            .o_count (w_bcnt_n[k]),
            .o_fire  (w_bfire[k]),
            .o_event (w_bev[k])
        );
    end

    for (genvar k = 0; k < ENC_LANES; k++) begin : g_enc
        localparam bit HAS_HI = (ENC_HI_BASE + k) < ENCODERS;
        localparam int HI_IDX = HAS_HI ? ENC_HI_BASE + k : k;
        logic w_sel_hi;
        logic w_en;

        assign w_sel_hi = HAS_HI && w_enc_hi;
        assign w_en     = w_enc_lo || w_sel_hi;

        bce_enc_lane u_lane (
            .i_code  (w_sel_hi ? r_code[HI_IDX] : r_code[k]),
            .i_half  (w_sel_hi ? r_half[HI_IDX] : r_half[k]),
            .i_pair  (s_axis_tdata[2*k +: 2]),
            .i_en    (w_en),
            .i_id    (w_sel_hi ? ID_W'(HI_IDX) : ID_W'(k)),
            .o_code  (w_ecode_n[k]),
            .o_half  (w_ehalf_n[k]),
            .o_fire  (w_efire[k]),
            .o_event (w_eev[k])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_code[k] <= 2'd0;
                r_half[k] <= 1'b0;
            end else if (w_accept && w_enc_lo) begin
                r_code[k] <= w_ecode_n[k];
                r_half[k] <= w_ehalf_n[k];
            end
        end

        if (HAS_HI) begin : g_hi
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_code[HI_IDX] <= 2'd0;
                    r_half[HI_IDX] <= 1'b0;
                end else if (w_accept && w_enc_hi) begin
                    r_code[HI_IDX] <= w_ecode_n[k];
                    r_half[HI_IDX] <= w_ehalf_n[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int k = 0; k < LANES; k++) begin
                    r_phase[r][k] <= PH_WAIT_PRESS;
                    r_count[r][k] <= 8'd0;
                end
            end
        end else if (w_accept && w_btn_en) begin
            for (int k = 0; k < LANES; k++) begin
                r_phase[w_row][k] <= w_bph_n[k];
                r_count[w_row][k] <= w_bcnt_n[k];
            end
        end
    end

    // one slot per button bit or encoder pair; a byte is either buttons or encoders
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_fire[k] = w_bfire[k];
            w_ev[k]   = w_bev[k];
        end
        for (int k = 0; k < ENC_LANES; k++) begin
            if (!w_btn_en) begin
                w_fire[k] = w_efire[k];
                w_ev[k]   = w_eev[k];
            end
        end
    end

    bce_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_fire  (w_fire),
        .i_ev    (w_ev),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_ev    (w_out),
        .o_last  (m_axis_tlast)
    );

    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata = {7'd0, w_out.step, w_out.id};
    assign m_axis_tuser = w_out.kind;

endmodule

`default_nettype wire

>>> verif/scan_event_checker.sv
`default_nettype none

module scan_event_checker
    import bce_pkg::*;
#(
    parameter logic [2:0] CFG_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [7:0]  i_in_tdata,    // [7:0] reg_byte
    input  logic [3:0]  i_in_tuser,    // [3:0] reg_index
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [15:0] i_out_tdata,   // [6:0] source_id, [8:7] step, rest zero
    input  logic [1:0]  i_out_tuser,   // [1:0] event_kind
    input  logic        i_out_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   id;
        logic signed [1:0] step;
        logic              last;
    } scan_event_t;

    t_phase      btn_phase [BUTTONS];
    logic [7:0]  btn_dead  [BUTTONS];
    logic [1:0]  enc_code  [ENCODERS];
    logic        enc_half  [ENCODERS];
    logic [7:0]  dead_scans;
    scan_event_t byte_events [$];
    scan_event_t expected_events [$];
    int          error_count = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic debounce_button(input int id, input logic released);
        case (btn_phase[id])
            PH_WAIT_PRESS: begin
                if (!released) begin
                    btn_dead[id]  = dead_scans;
                    btn_phase[id] = PH_PRESS_DEAD;
                    byte_events.push_back('{EV_PRESS, ID_W'(id), STEP_NONE, 1'b0});
                end
            end
            PH_PRESS_DEAD: begin
                btn_dead[id] = btn_dead[id] - 8'd1;
                if (btn_dead[id] == 8'd0)
                    btn_phase[id] = PH_WAIT_REL;
            end
            PH_WAIT_REL: begin
                if (released) begin
                    btn_dead[id]  = dead_scans;
                    btn_phase[id] = PH_REL_DEAD;
                    byte_events.push_back('{EV_RELEASE, ID_W'(id), STEP_NONE, 1'b0});
                end
            end
            default: begin
                btn_dead[id] = btn_dead[id] - 8'd1;
                if (btn_dead[id] == 8'd0)
                    btn_phase[id] = PH_WAIT_PRESS;
            end
        endcase
    endtask

    task automatic turn_encoder(input int id, input logic [1:0] pair);
        logic [1:0] code;
        logic [1:0] delta;
        code  = {pair[1], pair[1] ^ pair[0]};
        delta = enc_code[id] - code;
        if (delta[0]) begin
            enc_code[id] = code;
            if (delta == 2'd3) begin
                if (enc_half[id])
                    byte_events.push_back('{EV_DETENT, ID_W'(id), STEP_UP, 1'b0});
                enc_half[id] = !enc_half[id];
            end else begin
                if (!enc_half[id])
                    byte_events.push_back('{EV_DETENT, ID_W'(id), STEP_DOWN, 1'b0});
                enc_half[id] = !enc_half[id];
            end
        end
    endtask

    task automatic predict_scan_byte(input logic [3:0] idx, input logic [7:0] bits);
        byte_events.delete();
        if (idx <= REG_BTN_LAST) begin
            for (int b = 0; b < LANES; b++)
                debounce_button(LANES * int'(idx) + b, bits[b]);
        end else if (idx == REG_BTN_HI) begin
            for (int b = 0; b < LANES; b++)
                debounce_button(int'(ID_HI) + b, bits[b]);
        end else if (idx == REG_BTN_TOP) begin
            for (int b = 0; b < BUTTONS - int'(ID_TOP); b++)
                debounce_button(int'(ID_TOP) + b, bits[b]);
        end else if (idx == REG_ENC_LO) begin
            for (int b = 0; b < ENC_LANES; b++)
                turn_encoder(b, bits[2*b +: 2]);
        end else if (idx == REG_ENC_HI) begin
            for (int b = 0; b < ENCODERS - ENC_HI_BASE; b++)
                turn_encoder(ENC_HI_BASE + b, bits[2*b +: 2]);
        end
        if (byte_events.size() > 0)
            byte_events[byte_events.size() - 1].last = 1'b1;
        foreach (byte_events[i])
            expected_events.push_back(byte_events[i]);
    endtask

    always @(posedge i_clk) begin
        scan_event_t ev;
        if (!i_rst_n) begin
            dead_scans = DEAD_RESET;
            for (int i = 0; i < BUTTONS; i++) begin
                btn_phase[i] = PH_WAIT_PRESS;
                btn_dead[i]  = 8'd0;
            end
            for (int i = 0; i < ENCODERS; i++) begin
                enc_code[i] = 2'd0;
                enc_half[i] = 1'b0;
            end
            expected_events.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected event word: kind %0d id %0d",
                           i_out_tuser, i_out_tdata[ID_W-1:0]);
                    error_count++;
                end else begin
                    ev = expected_events.pop_front();
                    if (i_out_tuser != ev.kind) begin
                        $error("event_kind: expected %0d, got %0d", ev.kind, i_out_tuser);
                        error_count++;
                    end
                    if (i_out_tdata[ID_W-1:0] != ev.id) begin
                        $error("source_id: expected %0d, got %0d",
                               ev.id, i_out_tdata[ID_W-1:0]);
                        error_count++;
                    end
                    if ($signed(i_out_tdata[ID_W+1:ID_W]) != ev.step) begin
                        $error("step: expected %0d, got %0d",
                               ev.step, $signed(i_out_tdata[ID_W+1:ID_W]));
                        error_count++;
                    end
                    if (i_out_tlast != ev.last) begin
                        $error("last: expected %0d, got %0d", ev.last, i_out_tlast);
                        error_count++;
                    end
                    if (i_out_tdata[15:ID_W+2] != '0) begin
                        $error("tdata padding: expected 0, got %0h", i_out_tdata[15:ID_W+2]);
                        error_count++;
                    end
                end
            end
            if (i_psel && i_penable && i_pready && i_paddr == CFG_ADDR) begin
                if (i_pwrite) begin
                    dead_scans = i_pwdata[7:0];
                end else if (i_prdata != {24'd0, dead_scans}) begin
                    $error("dead_scans: expected %0d, got %0d", dead_scans, i_prdata);
                    error_count++;
                end
            end
            if (i_in_tvalid && i_in_tready)
                predict_scan_byte(i_in_tuser, i_in_tdata);
        end
        o_errors  <= error_count;
        o_pending <= expected_events.size();
    end

endmodule

`default_nettype wire

>>> verif/tb.sv
`default_nettype none

module tb;

    import bce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_DEAD_SCANS = 3'(4 * int'(CFG_DEAD_SCANS));
    localparam int         WATCHDOG_LIMIT  = 4000;
    localparam int         LONG_HOLD       = 400;
    localparam int         FRAME_LEN       = 13;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] reg_byte
    logic [3:0]  s_axis_tuser = '0;    // [3:0] reg_index
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [6:0] source_id, [8:7] step, rest zero
    logic [1:0]  m_axis_tuser;         // [1:0] event_kind
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          error_total;
    int          events_owed;
    int          stall_cycles = 0;
    int          burst_left = 0;
    logic        hold_request = 1'b0;
    logic [7:0]  held_rows [FRAME_LEN];
    logic [1:0]  wheel [ENCODERS];

    button_encoder_scan_decoder u_top (.*);

    scan_event_checker #(.CFG_ADDR(ADDR_DEAD_SCANS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .i_out_tlast  (m_axis_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_errors     (error_total),
        .o_pending    (events_owed)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[button_encoder_scan_decoder] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // receiver: random stall modes, plus one long hold on request
    initial begin
        int mode;
        int mode_left;
        bit hold_done;
        mode      = 0;
        mode_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (mode_left % 8 < 5);
                endcase
            end
        end
    end

    task automatic send_word(input logic [3:0] idx, input logic [7:0] bits);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= idx;
        s_axis_tdata  <= bits;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (events_owed != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ADDR_DEAD_SCANS;
        pwdata  <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // one scan in frame order; occasional stray, dropped or repeated words
    task automatic send_frame();
        logic [7:0] bits;
        int         pick;
        int         base;
        int         count;
        for (int r = 0; r < FRAME_LEN; r++) begin
            if ($urandom_range(0, 19) == 0)
                send_word(4'($urandom_range(FRAME_LEN, 15)), 8'($urandom));
            if ($urandom_range(0, 29) == 0)
                continue;
            bits = 8'($urandom);
            if (r == int'(REG_ENC_LO) || r == int'(REG_ENC_HI)) begin
                base  = (r == int'(REG_ENC_LO)) ? 0 : ENC_HI_BASE;
                count = (r == int'(REG_ENC_LO)) ? ENC_LANES : ENCODERS - ENC_HI_BASE;
                for (int e = 0; e < count; e++) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                        wheel[base+e] = wheel[base+e] + 2'd1;
                    else if (pick < 7)
                        wheel[base+e] = wheel[base+e] - 2'd1;
                    else if (pick == 9)
                        wheel[base+e] = wheel[base+e] + 2'd2;
                    bits[2*e +: 2] = {wheel[base+e][1], wheel[base+e][1] ^ wheel[base+e][0]};
                end
            end else begin
                held_rows[r] = held_rows[r] ^ 8'($urandom & $urandom);
                if ($urandom_range(0, 14) != 0)
                    bits = held_rows[r];
            end
            send_word(4'(r), bits);
            if ($urandom_range(0, 39) == 0)
                send_word(4'(r), bits);
        end
    endtask

    initial begin
        logic [7:0] dead_plan [6];
        int         frame_plan [6];
        dead_plan  = '{8'd1, 8'd2, 8'd3, 8'($urandom_range(1, 8)), 8'd255, 8'd0};
        frame_plan = '{8, 7, 7, 7, 3, 3};
        foreach (held_rows[i])
            held_rows[i] = 8'hFF;
        foreach (wheel[i])
            wheel[i] = 2'd0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, with the reset dead time
        send_word(4'd0, 8'h00);
        send_word(4'd0, 8'hFF);
        send_word(REG_BTN_LAST, 8'h00);
        send_word(REG_BTN_HI, 8'h00);
        send_word(REG_BTN_TOP, 8'h80);
        send_word(REG_BTN_TOP, 8'h00);
        send_word(4'd13, 8'h00);
        send_word(4'd14, 8'hFF);
        send_word(4'd15, 8'hAA);
        send_word(REG_ENC_LO, 8'h55);
        send_word(REG_ENC_LO, 8'hFF);
        send_word(REG_ENC_LO, 8'h55);
        send_word(REG_ENC_LO, 8'h00);
        send_word(REG_ENC_LO, 8'hAA);
        send_word(REG_ENC_LO, 8'h55);
        send_word(REG_ENC_HI, 8'h15);
        send_word(REG_ENC_HI, 8'hFF);
        send_word(REG_ENC_HI, 8'hC0);
        send_word(4'd5, 8'hA5);
        wait_idle();

        foreach (dead_plan[p]) begin
            apb_access(1'b1, dead_plan[p]);
            apb_access(1'b0, 8'd0);
            if (p == 0)
                hold_request = 1'b1;
            repeat (frame_plan[p]) send_frame();
            wait_idle();
        end

        repeat (16) @(posedge i_clk);
        if (error_total == 0)
            $display("[button_encoder_scan_decoder] OK");
        else
            $display("[button_encoder_scan_decoder] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/bce_pkg.sv
hw/rtl/bce_btn_lane.sv
hw/rtl/bce_enc_lane.sv
hw/rtl/bce_merge.sv
hw/rtl/button_encoder_scan_decoder.sv
verif/scan_event_checker.sv
verif/tb.sv
